FILE: hw/rtl/rgb_decimate_center_to_framebuffer_macros.svh
// Assertion macros used by the checker file of the decimating framebuffer writer.
`ifndef RGB_DECIMATE_CENTER_TO_FRAMEBUFFER_MACROS_SVH
`define RGB_DECIMATE_CENTER_TO_FRAMEBUFFER_MACROS_SVH

// Same-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define RDCF_ASSERT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define RDCF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rdcf_pkg.sv
// Types, constants and codes shared by the decimating framebuffer writer.
package rdcf_pkg;

  localparam int unsigned DISP_W   = 800;
  localparam int unsigned DISP_H   = 480;
  localparam int unsigned MAX_IMG  = 8192;

  localparam int unsigned SIZE_W   = 14;
  localparam int unsigned CNT_W    = 13;
  localparam int unsigned FACT_W   = 5;
  localparam int unsigned XW       = $clog2(DISP_W + 1);
  localparam int unsigned YW       = $clog2(DISP_H + 1);
  localparam int unsigned IDX_W    = 19;
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned DIV_W    = SIZE_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned IN_DATA_W  = 3 * PIX_W;
  localparam int unsigned OUT_FLD_W  = IDX_W + 3 * PIX_W;
  localparam int unsigned OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ITER,
    ST_FINISH,
    ST_RUN
  } ctrl_state_e;

  // Which of the two setup divisions the shared divider works on.
  typedef enum logic {
    OP_SW,
    OP_SH
  } div_op_e;

  typedef struct packed {
    div_op_e op;
    logic    div_load;
    logic    div_step;
    logic    div_capture;
    logic    finish;
    logic    run;
  } rdcf_cmd_t;

  typedef struct packed {
    logic div_done;
  } rdcf_stat_t;

endpackage

FILE: hw/rtl/rdcf_ctrl.sv
// Controller that sequences the per-frame setup divisions and then lets pixels stream.
module rdcf_ctrl
  import rdcf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  rdcf_stat_t stat_i,
  output rdcf_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  div_op_e     op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      op_q    <= OP_SW;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      ST_LOAD: state_d = ST_ITER;
      ST_ITER: begin
        if (stat_i.div_done) begin
          case (op_q)
            OP_SW: begin
              op_d    = OP_SH;
              state_d = ST_LOAD;
            end
            default: state_d = ST_FINISH;
          endcase
        end
      end
      ST_FINISH: state_d = ST_RUN;
      ST_RUN:    state_d = ST_RUN;
      default:   state_d = ST_LOAD;
    endcase
    // A register write restarts the whole setup.
    if (cfg_we_i) begin
      state_d = ST_LOAD;
      op_d    = OP_SW;
    end
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.op = op_q;
    case (state_q)
      ST_LOAD: cmd_o.div_load = 1'b1;
      ST_ITER: begin
        cmd_o.div_step    = !stat_i.div_done;
        cmd_o.div_capture = stat_i.div_done;
      end
      ST_FINISH: cmd_o.finish = 1'b1;
      ST_RUN:    cmd_o.run = 1'b1;
      default:   cmd_o.run = 1'b0;
    endcase
  end

endmodule

FILE: hw/rtl/rdcf_datapath.sv
// Datapath: size registers, shared divider, decimation counters and output register.
module rdcf_datapath
  import rdcf_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [SIZE_W-1:0]      cfg_data_i,
  input  rdcf_cmd_t              cmd_i,
  output rdcf_stat_t             stat_o,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [IN_DATA_W-1:0]   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_DATA_W-1:0]  out_data_o
);

  logic [SIZE_W-1:0] img_w_q, img_h_q;
  logic [SIZE_W-1:0] w_c, h_c;

  // Divider state.
  logic [DIV_W-1:0]     rem_q, quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     dvd, dvs;
  logic [DIV_W:0]       trial, diff;
  logic                 ge;

  // Frame setup results.
  logic [FACT_W-1:0] f_q, qw_c, qh_c, qmax_c, f_c;
  logic              big_c;
  logic [XW-1:0]     sw_q, left_c, col_lim_q;
  logic [YW-1:0]     sh_q, top_c, row_lim_q;
  logic [IDX_W-1:0]  base0_q, base0_c;

  // Pixel position.
  logic [CNT_W-1:0]  col_q, row_q;
  logic [FACT_W-1:0] col_ph_q, row_ph_q;
  logic [XW-1:0]     a_q;
  logic [YW-1:0]     b_q;
  logic [IDX_W-1:0]  row_base_q;
  logic [SIZE_W-1:0] col_nx, row_nx;
  logic              in_fire, keep;

  logic              out_valid_q;
  logic [IDX_W-1:0]  fb_index_q;
  logic [PIX_W-1:0]  ob0_q, ob1_q, ob2_q;

  // Quotient of a clamped size by a display dimension, found by comparing
  // against each multiple of the divisor.
  function automatic logic [FACT_W-1:0] quot_by_disp(input logic [SIZE_W-1:0] v,
                                                     input int unsigned d);
    logic [FACT_W-1:0] q;
    q = '0;
    for (int unsigned k = 1; k <= MAX_IMG / DISP_H; k++) begin
      if (32'(v) >= k * d) q = FACT_W'(k);
    end
    return q;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= SIZE_W'(DISP_W);
      img_h_q <= SIZE_W'(DISP_H);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  img_w_q <= cfg_data_i;
        CFG_IMAGE_HEIGHT: img_h_q <= cfg_data_i;
        default:          img_w_q <= img_w_q;
      endcase
    end
  end

  always_comb begin
    if (img_w_q == '0)                     w_c = SIZE_W'(1);
    else if (img_w_q > SIZE_W'(MAX_IMG))   w_c = SIZE_W'(MAX_IMG);
    else                                   w_c = img_w_q;
    if (img_h_q == '0)                     h_c = SIZE_W'(1);
    else if (img_h_q > SIZE_W'(MAX_IMG))   h_c = SIZE_W'(MAX_IMG);
    else                                   h_c = img_h_q;
  end

  assign qw_c   = quot_by_disp(w_c, DISP_W);
  assign qh_c   = quot_by_disp(h_c, DISP_H);
  assign qmax_c = (qw_c > qh_c) ? qw_c : qh_c;
  assign big_c  = (w_c > SIZE_W'(DISP_W)) || (h_c > SIZE_W'(DISP_H));
  assign f_c    = big_c ? qmax_c + FACT_W'(1) : FACT_W'(1);

  // The factor is fixed before the first division by it starts.
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load && (cmd_i.op == OP_SW)) begin
      f_q <= f_c;
    end
  end

  always_comb begin
    case (cmd_i.op)
      OP_SW:   dvd = w_c;
      OP_SH:   dvd = h_c;
      default: dvd = w_c;
    endcase
  end

  assign dvs = DIV_W'(f_q);

  // Restoring division, one quotient bit per cycle; the dividend shifts out of quo_q.
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_load) begin
      cnt_q <= DIV_CNT_W'(DIV_W);
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q <= '0;
      quo_q <= dvd;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign stat_o.div_done = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_capture) begin
      case (cmd_i.op)
        OP_SW:   sw_q <= quo_q[XW-1:0];
        OP_SH:   sh_q <= quo_q[YW-1:0];
        default: sw_q <= sw_q;
      endcase
    end
  end

  // Centering offsets and the framebuffer index of the first kept pixel.
  assign left_c  = (XW'(DISP_W) - sw_q) >> 1;
  assign top_c   = (YW'(DISP_H) - sh_q) >> 1;
  assign base0_c = IDX_W'(top_c) * IDX_W'(DISP_W) + IDX_W'(left_c);

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      col_lim_q <= XW'(DISP_W) - left_c;
      row_lim_q <= YW'(DISP_H) - top_c;
      base0_q   <= base0_c;
    end
  end

  assign in_ready_o = cmd_i.run && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign keep       = (col_ph_q == '0) && (row_ph_q == '0)
                      && (a_q < col_lim_q) && (b_q < row_lim_q);
  assign col_nx     = {1'b0, col_q} + SIZE_W'(1);
  assign row_nx     = {1'b0, row_q} + SIZE_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      col_ph_q   <= '0;
      row_ph_q   <= '0;
      a_q        <= '0;
      b_q        <= '0;
      row_base_q <= '0;
    end else if (cfg_we_i || cmd_i.finish) begin
      col_q      <= '0;
      row_q      <= '0;
      col_ph_q   <= '0;
      row_ph_q   <= '0;
      a_q        <= '0;
      b_q        <= '0;
      row_base_q <= base0_c;
    end else if (in_fire) begin
      if (col_nx >= w_c) begin
        col_q    <= '0;
        col_ph_q <= '0;
        a_q      <= '0;
        if (row_nx >= h_c) begin
          row_q      <= '0;
          row_ph_q   <= '0;
          b_q        <= '0;
          row_base_q <= base0_q;
        end else begin
          row_q <= row_nx[CNT_W-1:0];
          if (row_ph_q == f_q - FACT_W'(1)) begin
            row_ph_q   <= '0;
            b_q        <= b_q + YW'(1);
            row_base_q <= row_base_q + IDX_W'(DISP_W);
          end else begin
            row_ph_q <= row_ph_q + FACT_W'(1);
          end
        end
      end else begin
        col_q <= col_nx[CNT_W-1:0];
        if (col_ph_q == f_q - FACT_W'(1)) begin
          col_ph_q <= '0;
          a_q      <= a_q + XW'(1);
        end else begin
          col_ph_q <= col_ph_q + FACT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && keep) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Bytes leave in reversed order.
  always_ff @(posedge clk_i) begin
    if (in_fire && keep) begin
      fb_index_q <= row_base_q + IDX_W'(a_q);
      ob0_q      <= in_data_i[3*PIX_W-1:2*PIX_W];
      ob1_q      <= in_data_i[2*PIX_W-1:PIX_W];
      ob2_q      <= in_data_i[PIX_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {(OUT_DATA_W - OUT_FLD_W)'(0), ob2_q, ob1_q, ob0_q, fb_index_q};

endmodule

FILE: hw/rtl/rgb_decimate_center_to_framebuffer.sv
// Top level: integer downscaler that centers an RGB raster on an 800x480 framebuffer.
//
//  channel  direction  handshake                     payload
//  s_axis   in         s_axis_tvalid/s_axis_tready   source pixel (3 bytes)
//  m_axis   out        m_axis_tvalid/m_axis_tready   framebuffer index + BGR pixel
//  cfg      in         cfg_we_i (always taken)       image_width / image_height
//
//  After reset and after every register write the block runs its setup: the shrink factor
//  comes from compares against multiples of the display size, then two 14-bit divisions
//  run on the shared restoring divider and a finish step sets the centering offsets.
//  s_axis_tready stays low during that time. Then one item is taken per cycle unless
//  m_axis stalls; a kept pixel is registered and reaches m_axis in the next cycle.
//  A stalled m_axis holds s_axis only while the output register is full.
module rgb_decimate_center_to_framebuffer
  import rdcf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [SIZE_W-1:0]     cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // src_byte0 [7:0], src_byte1 [15:8], src_byte2 [23:16]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // fb_index [18:0], out_byte0 [26:19], out_byte1 [34:27], out_byte2 [42:35], zero [47:43]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  rdcf_cmd_t  cmd;
  rdcf_stat_t stat;

  rdcf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_we_i (cfg_we_i),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  rdcf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

FILE: hw/rtl/rdcf_checker.sv
// Port-level checker for the decimating framebuffer writer, bound to the top level.
`include "rgb_decimate_center_to_framebuffer_macros.svh"

module rdcf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  logic out_stall;

  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // A stalled result keeps its valid and its payload.
  `RDCF_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "item changed")

  // A register write restarts setup, so no item is taken right after it.
  `RDCF_ASSERT_NEXT(a_cfg_stall, cfg_we_i, !s_axis_tready, "item accepted during setup")

  // Every index lands inside the display.
  `RDCF_ASSERT(a_idx_range, m_axis_tvalid, m_axis_tdata[18:0] < 19'd384000, "index off display")

endmodule

bind rgb_decimate_center_to_framebuffer rdcf_checker u_rdcf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/sv/rgb_decimate_center_to_framebuffer_tb.sv
// Self-checking testbench for the decimating framebuffer writer: random stream traffic and scoring.
module rgb_decimate_center_to_framebuffer_tb
  import rdcf_pkg::*;
;

  localparam int unsigned LONG_HOLD  = 300;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned SETTLE     = 8;
  localparam int unsigned RAND_ITEMS = 400;

  // Packed so that it lines up with the low bits of m_axis_tdata.
  typedef struct packed {
    logic [PIX_W-1:0] byte2;
    logic [PIX_W-1:0] byte1;
    logic [PIX_W-1:0] byte0;
    logic [IDX_W-1:0] fb_index;
  } fb_write_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_IMAGE_WIDTH;
  logic [SIZE_W-1:0]     cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  rgb_decimate_center_to_framebuffer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  logic [IN_DATA_W-1:0] pixel_q[$];
  fb_write_t            fb_write_q[$];
  fb_write_t            got;
  fb_write_t            want;
  int unsigned          mismatches = 0;
  int unsigned          idle_cycles = 0;
  int unsigned          tx_gap = 0;
  int unsigned          rx_pause = 0;
  int unsigned          holds_asked = 0;
  int unsigned          holds_taken = 0;
  bit                   tx_steady = 1'b0;
  bit                   rx_steady = 1'b0;

  // Mirror of the block: size registers, raster position and per-frame setup.
  logic [SIZE_W-1:0] img_w_reg = 14'd800;
  logic [SIZE_W-1:0] img_h_reg = 14'd480;
  int unsigned       col_pos = 0;
  int unsigned       row_pos = 0;
  int unsigned       factor = 1;
  int unsigned       left_off = 0;
  int unsigned       top_off = 0;
  bit                frame_ready = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned sized(logic [SIZE_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_IMG) return MAX_IMG;
    return 32'(v);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(1, 2);
    if (r < 9) return $urandom_range(3, 8);
    return $urandom_range(15, 60);
  endfunction

  task automatic predict_fb_write(input logic [IN_DATA_W-1:0] px);
    int unsigned w, h, qw, qh, a, b, idx;
    fb_write_t r;
    w = sized(img_w_reg);
    h = sized(img_h_reg);
    if (!frame_ready) begin
      factor = 1;
      if (w > DISP_W || h > DISP_H) begin
        qw = w / DISP_W;
        qh = h / DISP_H;
        factor = (qw > qh ? qw : qh) + 1;
      end
      left_off = (DISP_W - w / factor) / 2;
      top_off = (DISP_H - h / factor) / 2;
      frame_ready = 1'b1;
    end
    if (col_pos % factor == 0 && row_pos % factor == 0) begin
      a = col_pos / factor;
      b = row_pos / factor;
      if (a < DISP_W - left_off && b < DISP_H - top_off) begin
        idx = (top_off + b) * DISP_W + left_off + a;
        r.fb_index = idx[IDX_W-1:0];
        r.byte0 = px[23:16];
        r.byte1 = px[15:8];
        r.byte2 = px[7:0];
        fb_write_q.push_back(r);
      end
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        row_pos = 0;
        frame_ready = 1'b0;
      end else begin
        row_pos = row_pos + 1;
      end
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch: %s: expected idx %0d bytes %02h %02h %02h,",
               what, want.fb_index, want.byte0, want.byte1, want.byte2,
               " got idx %0d bytes %02h %02h %02h",
               got.fb_index, got.byte0, got.byte1, got.byte2);
    end
  endtask

  // Any write restarts the frame, so the raster position goes back to the origin.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    if (idx == CFG_IMAGE_WIDTH) img_w_reg = val;
    else img_h_reg = val;
    col_pos = 0;
    row_pos = 0;
    frame_ready = 1'b0;
  endtask

  task automatic set_size(input bit set_w, input bit set_h,
                          input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    if (set_w) write_reg(CFG_IMAGE_WIDTH, w);
    if (set_h) write_reg(CFG_IMAGE_HEIGHT, h);
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle_block();
    while (pixel_q.size() != 0 || s_axis_tvalid || fb_write_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) pixel_q.push_back(IN_DATA_W'($urandom));
  endtask

  // Source side: one item in flight, a random gap after some of them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      tx_gap = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) predict_fb_write(s_axis_tdata);
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        s_axis_tdata <= pixel_q.pop_front();
        s_axis_tvalid <= 1'b1;
        if (!tx_steady && $urandom_range(0, 2) == 0) tx_gap = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Framebuffer side: score each write, stall at random or for one long hold.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_pause = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[OUT_FLD_W-1:0];
        if (fb_write_q.size() == 0) begin
          want = '0;
          note_mismatch("unexpected write");
        end else begin
          want = fb_write_q.pop_front();
          if (got.fb_index !== want.fb_index) note_mismatch("fb_index");
          if (got.byte0 !== want.byte0) note_mismatch("out_byte0");
          if (got.byte1 !== want.byte1) note_mismatch("out_byte1");
          if (got.byte2 !== want.byte2) note_mismatch("out_byte2");
        end
      end
      if (holds_taken != holds_asked) begin
        holds_taken = holds_asked;
        rx_pause = LONG_HOLD;
      end
      if (rx_pause > 0) begin
        rx_pause--;
        m_axis_tready <= 1'b0;
      end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
        rx_pause = pick_gap() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    int unsigned n;
    int unsigned sent;
    int unsigned k;
    int unsigned sel;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset size 800x480 fits the display as it is.
    pixel_q.push_back(24'h000000);
    pixel_q.push_back(24'hFFFFFF);
    pixel_q.push_back(24'h0F55AA);
    settle_block();

    // Zero sizes read as 1x1, so every item is a whole frame.
    set_size(1'b1, 1'b1, '0, '0);
    pixel_q.push_back(24'hA5C3F0);
    pixel_q.push_back(24'h5A3C0F);
    settle_block();

    // Width above the maximum clamps to 8192; the factor is then 11.
    set_size(1'b1, 1'b1, 14'h3FFF, '0);
    push_random(12);
    settle_block();

    // One column too wide: factor 2, only width rewritten.
    set_size(1'b1, 1'b0, 14'd801, '0);
    push_random(3);
    settle_block();

    // One row too tall: factor 2, odd rows are dropped.
    set_size(1'b1, 1'b1, 14'd3, 14'd481);
    push_random(4);
    settle_block();

    // Tiny frame so that the stream runs past the end of a frame and wraps to the origin.
    set_size(1'b1, 1'b1, 14'd2, 14'd2);
    push_random(5);

    sent = 0;
    k = 0;
    while (sent < RAND_ITEMS) begin
      settle_block();
      if (k == 1) begin
        // Hold the framebuffer side long enough for the source side to back up.
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        set_size(1'b1, 1'b1, 14'd16, 14'd8);
        holds_asked++;
        n = 64;
      end else begin
        sel = $urandom_range(0, 19);
        if (sel < 14) begin
          w = SIZE_W'($urandom_range(1, 24));
          h = SIZE_W'($urandom_range(1, 12));
        end else if (sel < 17) begin
          w = SIZE_W'($urandom_range(780, 2500));
          h = SIZE_W'($urandom_range(1, 3));
        end else if (sel == 17) begin
          w = SIZE_W'($urandom_range(1, 6));
          h = SIZE_W'($urandom_range(470, 1500));
        end else begin
          w = SIZE_W'($urandom);
          h = SIZE_W'($urandom);
        end
        tx_steady = ($urandom_range(0, 4) == 0);
        rx_steady = ($urandom_range(0, 4) == 0);
        case ($urandom_range(0, 3))
          0: set_size(1'b1, 1'b0, w, h);
          1: set_size(1'b0, 1'b1, w, h);
          default: set_size(1'b1, 1'b1, w, h);
        endcase
        n = $urandom_range(8, 50);
      end
      push_random(n);
      sent += n;
      k++;
    end

    settle_block();
    if (mismatches == 0 && fb_write_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/rdcf_pkg.sv
hw/rtl/rdcf_ctrl.sv
hw/rtl/rdcf_datapath.sv
hw/rtl/rgb_decimate_center_to_framebuffer.sv
hw/rtl/rdcf_checker.sv
tb/sv/rgb_decimate_center_to_framebuffer_tb.sv
